// ===== src/ppv_pkg.sv =====
// Shared types and constants for the perspective projection / viewport unit.
`timescale 1ns / 1ps

package ppv_pkg;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_ROW0_XY  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW0_ZT  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_XY  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_ZT  = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW3_XY  = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROW3_ZT  = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H = 4'd7;

	localparam int unsigned SCR_DIM_W = 14;
	localparam logic [SCR_DIM_W-1:0] SCREEN_W_RST = 14'd1920;
	localparam logic [SCR_DIM_W-1:0] SCREEN_H_RST = 14'd1080;

	// Smallest raw Q16.16 w that is not below 0.65
	localparam logic [47:0] W_VISIBLE_MIN = 48'd42599;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} ppv_point_t;

	typedef struct packed {
		logic               visible;
		logic signed [31:0] screen_x;
		logic signed [31:0] screen_y;
		logic        [30:0] depth_w;
	} ppv_proj_t;

endpackage

// ===== src/perspective_projection_viewport_unit.sv =====
// Top level: world point to screen point projection pipeline with viewport mapping.
`timescale 1ns / 1ps

// Perspective projection unit. Each transfer on the point channel carries one
// signed Q16.16 world point; exactly one result comes back on the proj channel,
// in order. The point goes through matrix rows 0, 1 and 3 (cx, cy, w); a point
// with w below 0.65 is reported as not visible with all other fields zero.
// Otherwise screen_x = W/2 + (W/2)*cx/w and screen_y = H/2 - (H/2)*cy/w,
// truncated toward zero and saturated to 32 bits, and depth_w is w saturated
// to 31 bits. Throughput is one point per clock while proj does not stall.
// There are 40 register stages, the first loaded at the input transfer edge.
// The latency is set by the two 33-stage restoring dividers (one quotient bit
// per stage) that form the middle of the pipeline; ahead of them sit the 32x32
// multiplier stage, the row sum, the sign split, two stages for the wide
// half-size product and the overflow check, and behind them the saturating
// output register. A single-entry skid buffer at the input keeps point_ready
// registered, so a new point is taken even while the finished result waits on
// proj_ready. Configuration writes are always accepted (cfg_ready is high);
// write only while no point is in flight. Indexes above 7 are ignored.
module perspective_projection_viewport_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// point channel
	input  logic                          point_valid,
	output logic                          point_ready,
	input  ppv_pkg::ppv_point_t           point,
	// result channel
	output logic                          proj_valid,
	input  logic                          proj_ready,
	output ppv_pkg::ppv_proj_t            proj,
	// configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ppv_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_data
);
	import ppv_pkg::*;

	localparam int unsigned DIV_STEPS = 33;	// quotient bits kept below the overflow point

	// per-item state through the divider stages
	typedef struct packed {
		logic        vis;
		logic [30:0] depth;
		logic [28:0] hx;
		logic [28:0] hy;
		logic [47:0] w;
		logic        negx;
		logic        ovfx;
		logic [47:0] rx;
		logic [32:0] nx;
		logic [32:0] qx;
		logic        negy;
		logic        ovfy;
		logic [47:0] ry;
		logic [32:0] ny;
		logic [32:0] qy;
	} div_t;

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	logic [63:0]          row0_xy_q, row0_zt_q, row1_xy_q, row1_zt_q, row3_xy_q, row3_zt_q;
	logic [SCR_DIM_W-1:0] scr_w_q, scr_h_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0_xy_q <= '0;
			row0_zt_q <= '0;
			row1_xy_q <= '0;
			row1_zt_q <= '0;
			row3_xy_q <= '0;
			row3_zt_q <= '0;
			scr_w_q   <= SCREEN_W_RST;
			scr_h_q   <= SCREEN_H_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROW0_XY:  row0_xy_q <= cfg_data;
				REG_ROW0_ZT:  row0_zt_q <= cfg_data;
				REG_ROW1_XY:  row1_xy_q <= cfg_data;
				REG_ROW1_ZT:  row1_zt_q <= cfg_data;
				REG_ROW3_XY:  row3_xy_q <= cfg_data;
				REG_ROW3_ZT:  row3_zt_q <= cfg_data;
				REG_SCREEN_W: scr_w_q   <= cfg_data[SCR_DIM_W-1:0];
				REG_SCREEN_H: scr_h_q   <= cfg_data[SCR_DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// helpers
	// ---------------------------------------------------------------
	// floor each Q32.32 product to Q16.16, add the translation column
	function automatic logic signed [48:0] row_sum(
		input logic signed [63:0] p0,
		input logic signed [63:0] p1,
		input logic signed [63:0] p2,
		input logic        [31:0] t
	);
		logic signed [48:0] a, b, c, d;
		a = $signed({p0[63], p0[63:16]});
		b = $signed({p1[63], p1[63:16]});
		c = $signed({p2[63], p2[63:16]});
		d = $signed({{17{t[31]}}, t});
		return a + b + c + d;
	endfunction

	// one restoring division step for both coordinates
	function automatic div_t div_step(input div_t d);
		logic [48:0] tx, ty, wd;
		div_t        o;
		o  = d;
		wd = {1'b0, d.w};
		tx = {d.rx, d.nx[32]};
		ty = {d.ry, d.ny[32]};
		if (tx >= wd) begin
			o.rx = 48'(tx - wd);
			o.qx = {d.qx[31:0], 1'b1};
		end else begin
			o.rx = tx[47:0];
			o.qx = {d.qx[31:0], 1'b0};
		end
		if (ty >= wd) begin
			o.ry = 48'(ty - wd);
			o.qy = {d.qy[31:0], 1'b1};
		end else begin
			o.ry = ty[47:0];
			o.qy = {d.qy[31:0], 1'b0};
		end
		o.nx = {d.nx[31:0], 1'b0};
		o.ny = {d.ny[31:0], 1'b0};
		return o;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		if (v > 36'sh0_7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		else if (v < -36'sh0_8000_0000)
			return 32'sh8000_0000;
		else
			return v[31:0];
	endfunction

	// ---------------------------------------------------------------
	// input skid buffer and pipeline advance
	// ---------------------------------------------------------------
	logic       en;          // whole pipeline moves one stage
	logic       skid_vld_q;
	ppv_point_t skid_q;
	logic       ent_vld;
	ppv_point_t ent;

	assign en          = !proj_valid || proj_ready;
	assign point_ready = !skid_vld_q;
	assign ent_vld     = skid_vld_q || point_valid;
	assign ent         = skid_vld_q ? skid_q : point;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (en) begin
			skid_vld_q <= 1'b0;
		end else if (point_valid && point_ready) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && point_valid && point_ready) begin
			skid_q <= point;
		end
	end

	// ---------------------------------------------------------------
	// pipeline valid bits
	// ---------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic dv_vld_s [0:DIV_STEPS];
	logic vld_s40;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s40 <= 1'b0;
			for (int k = 0; k <= DIV_STEPS; k++) begin
				dv_vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s1      <= ent_vld;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			vld_s5      <= vld_s4;
			dv_vld_s[0] <= vld_s5;
			for (int k = 1; k <= DIV_STEPS; k++) begin
				dv_vld_s[k] <= dv_vld_s[k-1];
			end
			vld_s40     <= dv_vld_s[DIV_STEPS];
		end
	end

	assign proj_valid = vld_s40;

	// ---------------------------------------------------------------
	// stage 1: nine 32x32 signed products (rows 0, 1, 3)
	// ---------------------------------------------------------------
	logic signed [63:0] prod_s1 [0:8];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1[0] <= $signed(row0_xy_q[31:0])  * ent.pos_x;
			prod_s1[1] <= $signed(row0_xy_q[63:32]) * ent.pos_y;
			prod_s1[2] <= $signed(row0_zt_q[31:0])  * ent.pos_z;
			prod_s1[3] <= $signed(row1_xy_q[31:0])  * ent.pos_x;
			prod_s1[4] <= $signed(row1_xy_q[63:32]) * ent.pos_y;
			prod_s1[5] <= $signed(row1_zt_q[31:0])  * ent.pos_z;
			prod_s1[6] <= $signed(row3_xy_q[31:0])  * ent.pos_x;
			prod_s1[7] <= $signed(row3_xy_q[63:32]) * ent.pos_y;
			prod_s1[8] <= $signed(row3_zt_q[31:0])  * ent.pos_z;
		end
	end

	// ---------------------------------------------------------------
	// stage 2: clip cx, cy, w (|value| < 2^48)
	// ---------------------------------------------------------------
	logic signed [48:0] cx_s2, cy_s2, w_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s2 <= row_sum(prod_s1[0], prod_s1[1], prod_s1[2], row0_zt_q[63:32]);
			cy_s2 <= row_sum(prod_s1[3], prod_s1[4], prod_s1[5], row1_zt_q[63:32]);
			w_s2  <= row_sum(prod_s1[6], prod_s1[7], prod_s1[8], row3_zt_q[63:32]);
		end
	end

	// ---------------------------------------------------------------
	// stage 3: visibility, depth, sign/magnitude split, half sizes
	// ---------------------------------------------------------------
	logic        vis_s3, negx_s3, negy_s3;
	logic [30:0] depth_s3;
	logic [47:0] w_s3, magx_s3, magy_s3;
	logic [28:0] hx_s3, hy_s3;
	logic [48:0] negcx, negcy;

	assign negcx = 49'(-cx_s2);
	assign negcy = 49'(-cy_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			vis_s3   <= !w_s2[48] && (w_s2[47:0] >= W_VISIBLE_MIN);
			depth_s3 <= (w_s2[47:31] != '0) ? '1 : w_s2[30:0];
			w_s3     <= w_s2[47:0];
			negx_s3  <= cx_s2[48];
			negy_s3  <= cy_s2[48];
			magx_s3  <= cx_s2[48] ? negcx[47:0] : cx_s2[47:0];
			magy_s3  <= cy_s2[48] ? negcy[47:0] : cy_s2[47:0];
			// W/2 in Q16.16 is W * 2^15
			hx_s3    <= {scr_w_q, 15'd0};
			hy_s3    <= {scr_h_q, 15'd0};
		end
	end

	// ---------------------------------------------------------------
	// stage 4: half * |c| as two 29x24 partial products each
	// ---------------------------------------------------------------
	logic        vis_s4, negx_s4, negy_s4;
	logic [30:0] depth_s4;
	logic [47:0] w_s4;
	logic [28:0] hx_s4, hy_s4;
	logic [52:0] ppx_lo_s4, ppx_hi_s4, ppy_lo_s4, ppy_hi_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			vis_s4    <= vis_s3;
			depth_s4  <= depth_s3;
			w_s4      <= w_s3;
			negx_s4   <= negx_s3;
			negy_s4   <= negy_s3;
			hx_s4     <= hx_s3;
			hy_s4     <= hy_s3;
			ppx_lo_s4 <= hx_s3 * magx_s3[23:0];
			ppx_hi_s4 <= hx_s3 * magx_s3[47:24];
			ppy_lo_s4 <= hy_s3 * magy_s3[23:0];
			ppy_hi_s4 <= hy_s3 * magy_s3[47:24];
		end
	end

	// ---------------------------------------------------------------
	// stage 5: recombine dividends (< 2^77)
	// ---------------------------------------------------------------
	logic        vis_s5, negx_s5, negy_s5;
	logic [30:0] depth_s5;
	logic [47:0] w_s5;
	logic [28:0] hx_s5, hy_s5;
	logic [76:0] nx_s5, ny_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			vis_s5   <= vis_s4;
			depth_s5 <= depth_s4;
			w_s5     <= w_s4;
			negx_s5  <= negx_s4;
			negy_s5  <= negy_s4;
			hx_s5    <= hx_s4;
			hy_s5    <= hy_s4;
			nx_s5    <= 77'(ppx_lo_s4) + {ppx_hi_s4, 24'd0};
			ny_s5    <= 77'(ppy_lo_s4) + {ppy_hi_s4, 24'd0};
		end
	end

	// ---------------------------------------------------------------
	// stages 6..39: overflow check, then one quotient bit per stage.
	// A quotient of 2^33 or more saturates either coordinate, so only
	// the low 33 bits are developed; the top dividend bits seed the
	// partial remainder.
	// ---------------------------------------------------------------
	div_t div_s [0:DIV_STEPS];
	div_t div_ent;

	always_comb begin
		div_ent.vis   = vis_s5;
		div_ent.depth = depth_s5;
		div_ent.hx    = hx_s5;
		div_ent.hy    = hy_s5;
		div_ent.w     = w_s5;
		div_ent.negx  = negx_s5;
		div_ent.ovfx  = {4'd0, nx_s5[76:33]} >= w_s5;
		div_ent.rx    = {4'd0, nx_s5[76:33]};
		div_ent.nx    = nx_s5[32:0];
		div_ent.qx    = '0;
		div_ent.negy  = negy_s5;
		div_ent.ovfy  = {4'd0, ny_s5[76:33]} >= w_s5;
		div_ent.ry    = {4'd0, ny_s5[76:33]};
		div_ent.ny    = ny_s5[32:0];
		div_ent.qy    = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0] <= div_ent;
			for (int k = 1; k <= DIV_STEPS; k++) begin
				div_s[k] <= div_step(div_s[k-1]);
			end
		end
	end

	// ---------------------------------------------------------------
	// stage 40: viewport offset, saturation, output register
	// ---------------------------------------------------------------
	div_t               fin;
	logic signed [35:0] qx_sg, qy_sg, sx_sum, sy_sum;
	logic signed [31:0] sx, sy;
	ppv_proj_t          res;
	ppv_proj_t          proj_s40;

	assign fin = div_s[DIV_STEPS];

	always_comb begin
		qx_sg  = $signed({3'd0, fin.qx});
		qy_sg  = $signed({3'd0, fin.qy});
		sx_sum = $signed({7'd0, fin.hx}) + (fin.negx ? -qx_sg : qx_sg);
		sy_sum = $signed({7'd0, fin.hy}) - (fin.negy ? -qy_sg : qy_sg);
		if (fin.ovfx)
			sx = fin.negx ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		else
			sx = sat32(sx_sum);
		if (fin.ovfy)
			sy = fin.negy ? 32'sh7FFF_FFFF : 32'sh8000_0000;
		else
			sy = sat32(sy_sum);
		if (fin.vis) begin
			res.visible  = 1'b1;
			res.screen_x = sx;
			res.screen_y = sy;
			res.depth_w  = fin.depth;
		end else begin
			res = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			proj_s40 <= res;
		end
	end

	assign proj = proj_s40;

`ifndef SYNTH
	// a point that arrives during a stall is parked in the skid buffer
	a_skid_catch: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && point_ready && !en |=> skid_vld_q)
		else $error("stalled input transfer not captured");

	// the skid buffer drains as soon as the pipeline moves
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && en |=> !skid_vld_q)
		else $error("skid buffer not drained on advance");

	// hidden points carry no coordinates or depth
	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		proj_valid && !proj.visible |->
			proj.screen_x == '0 && proj.screen_y == '0 && proj.depth_w == '0)
		else $error("not-visible result with nonzero fields");

	// visible points always have depth at the threshold or above
	a_vis_depth: assert property (@(posedge clk) disable iff (!arst_n)
		proj_valid && proj.visible |-> proj.depth_w >= 31'd42599)
		else $error("visible result below depth threshold");
`endif

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the perspective projection / viewport unit.
`timescale 1ns / 1ps

module tb_top;
	import ppv_pkg::*;

	// Run length and timing
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned RANDOM_PHASES = 12;
	localparam int unsigned PHASE_POINTS  = 125;
	localparam int unsigned DRAIN_CYCLES  = 60;

	// Index outside the register map; low bits alias screen_width to catch partial decode
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd14;

	localparam logic [31:0] FX_ONE = 32'h0001_0000; // 1.0 in Q16.16

	// Golden model plus in-order store of projections still owed by the DUT.
	class proj_checker;
		bit [63:0] row0_xy, row0_zt, row1_xy, row1_zt, row3_xy, row3_zt;
		bit [SCR_DIM_W-1:0] scr_w, scr_h;
		ppv_proj_t expected_proj[$];
		int errors;

		function new();
			scr_w = SCREEN_W_RST;
			scr_h = SCREEN_H_RST;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
			case (idx)
			REG_ROW0_XY: row0_xy = data;
			REG_ROW0_ZT: row0_zt = data;
			REG_ROW1_XY: row1_xy = data;
			REG_ROW1_ZT: row1_zt = data;
			REG_ROW3_XY: row3_xy = data;
			REG_ROW3_ZT: row3_zt = data;
			REG_SCREEN_W: scr_w = data[SCR_DIM_W-1:0];
			REG_SCREEN_H: scr_h = data[SCR_DIM_W-1:0];
			default: ; // unmapped index, dropped
			endcase
		endfunction

		// Q16.16 x Q16.16, floored back to Q16.16
		function logic signed [63:0] fx_mul(logic signed [31:0] m, logic signed [31:0] v);
			logic signed [63:0] a, b;
			a = m;
			b = v;
			return (a * b) >>> 16;
		endfunction

		function logic signed [63:0] row_dot(bit [63:0] xy, bit [63:0] zt, ppv_point_t p);
			logic signed [63:0] offs;
			offs = $signed(zt[63:32]);
			return fx_mul(xy[31:0], p.pos_x) + fx_mul(xy[63:32], p.pos_y)
				+ fx_mul(zt[31:0], p.pos_z) + offs;
		endfunction

		// (dim/2) * c / w, exact, truncated toward zero
		function logic signed [127:0] view_term(bit [SCR_DIM_W-1:0] dim,
			logic signed [63:0] c, logic signed [63:0] w);
			logic signed [63:0] ac;
			logic [127:0] half, mag, q;
			ac = (c < 0) ? -c : c;
			half = 128'(dim) << 15;
			mag = 128'(ac);
			q = (half * mag) / 128'(w);
			return (c < 0) ? -$signed(q) : $signed(q);
		endfunction

		function logic signed [31:0] sat32(logic signed [127:0] v);
			if (v > 128'sh7FFF_FFFF)
				return 32'sh7FFF_FFFF;
			if (v < -128'sh8000_0000)
				return 32'sh8000_0000;
			return v[31:0];
		endfunction

		function ppv_proj_t project_point(ppv_point_t p);
			logic signed [63:0] w, cx, cy;
			logic signed [127:0] hx, hy;
			ppv_proj_t r;
			r = '0;
			w = row_dot(row3_xy, row3_zt, p);
			if (w < longint'(W_VISIBLE_MIN))
				return r;
			cx = row_dot(row0_xy, row0_zt, p);
			cy = row_dot(row1_xy, row1_zt, p);
			hx = 128'(scr_w) << 15;
			hy = 128'(scr_h) << 15;
			r.visible  = 1'b1;
			r.screen_x = sat32(hx + view_term(scr_w, cx, w));
			r.screen_y = sat32(hy - view_term(scr_h, cy, w));
			r.depth_w  = (w > 64'sh7FFF_FFFF) ? 31'h7FFF_FFFF : w[30:0];
			return r;
		endfunction

		function void note_point(ppv_point_t p);
			expected_proj = {expected_proj, project_point(p)};
		endfunction

		function int pending();
			return expected_proj.size();
		endfunction

		function void check_proj(ppv_proj_t got);
			ppv_proj_t want;
			if (expected_proj.size() == 0) begin
				$error("projection transfer with no point outstanding");
				errors++;
				return;
			end
			want = expected_proj.pop_front();
			if (got.visible !== want.visible) begin
				$error("visible: expected %0d, actual %0d", want.visible, got.visible);
				errors++;
			end
			if (got.screen_x !== want.screen_x) begin
				$error("screen_x: expected %0d, actual %0d", want.screen_x, got.screen_x);
				errors++;
			end
			if (got.screen_y !== want.screen_y) begin
				$error("screen_y: expected %0d, actual %0d", want.screen_y, got.screen_y);
				errors++;
			end
			if (got.depth_w !== want.depth_w) begin
				$error("depth_w: expected %0d, actual %0d", want.depth_w, got.depth_w);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic point_valid;
	logic point_ready;
	ppv_point_t point;
	logic proj_valid;
	logic proj_ready;
	ppv_proj_t proj;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [63:0] cfg_data;

	proj_checker sb = new();
	int unsigned cycle_count;
	bit src_burst; // sender runs back to back while set
	bit snk_burst; // receiver never stalls while set

	perspective_projection_viewport_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.point_valid(point_valid),
		.point_ready(point_ready),
		.point(point),
		.proj_valid(proj_valid),
		.proj_ready(proj_ready),
		.proj(proj),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case a transfer never completes
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic ppv_point_t pt(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		return {x, y, z};
	endfunction

	// Uniform signed Q16.16 value in [-mag, +mag] (raw units)
	function automatic logic [31:0] rand_fixed(int unsigned mag);
		return 32'($urandom_range(0, 2 * mag)) - mag;
	endfunction

	// Viewport size: mostly the legal span, with both edges and the out-of-range values
	function automatic logic [SCR_DIM_W-1:0] rand_dim();
		case ($urandom_range(0, 7))
		0: return 14'd0;
		1: return 14'd1;
		2: return 14'd8192;
		3: return 14'd16383;
		default: return 14'($urandom_range(1, 8192));
		endcase
	endfunction

	// Mostly points in front of a sane camera; the rest raw 32-bit noise
	function automatic ppv_point_t rand_point();
		if ($urandom_range(0, 9) < 3)
			return {$urandom, $urandom, $urandom};
		return pt(rand_fixed(2048 << 16), rand_fixed(2048 << 16),
			32'($urandom_range(0, 512 << 16)) - (64 << 16));
	endfunction

	// One config transfer; cfg_valid is left high so writes can go back to back
	task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// Full register load; optionally ends with a write to an unmapped index
	task automatic load_setup(logic [63:0] r0xy, logic [63:0] r0zt, logic [63:0] r1xy,
		logic [63:0] r1zt, logic [63:0] r3xy, logic [63:0] r3zt,
		logic [63:0] wdata, logic [63:0] hdata, bit stray);
		put_reg(REG_ROW0_XY, r0xy);
		put_reg(REG_ROW0_ZT, r0zt);
		put_reg(REG_ROW1_XY, r1xy);
		put_reg(REG_ROW1_ZT, r1zt);
		put_reg(REG_ROW3_XY, r3xy);
		put_reg(REG_ROW3_ZT, r3zt);
		put_reg(REG_SCREEN_W, wdata);
		put_reg(REG_SCREEN_H, hdata);
		if (stray)
			put_reg(REG_UNUSED, 64'h0);
		cfg_valid <= 1'b0;
	endtask

	// Random matrix per phase:
	//   style 0 - raw 32-bit words, screen coords mostly saturate
	//   style 1 - moderate entries, row 3 biased so most points are visible
	//   style 2 - moderate entries, row 3 of either sign
	task automatic random_setup();
		logic [31:0] m[12]; // rows 0, 1, 3; four columns each
		logic [63:0] wdata, hdata;
		int style;
		style = $urandom_range(0, 2);
		for (int i = 0; i < 12; i++) begin
			if (style == 0)
				m[i] = $urandom;
			else if (i % 4 == 3)
				m[i] = rand_fixed(256 << 16);
			else
				m[i] = rand_fixed(8 << 16);
		end
		if (style == 1) begin
			m[8]  = rand_fixed(1 << 15);
			m[9]  = rand_fixed(1 << 15);
			m[10] = $urandom_range(1 << 15, 4 << 16);
			m[11] = $urandom_range(0, 16 << 16);
		end
		// upper data bits are don't-care for the size registers
		wdata = {$urandom, $urandom};
		wdata[SCR_DIM_W-1:0] = rand_dim();
		hdata = {$urandom, $urandom};
		hdata[SCR_DIM_W-1:0] = rand_dim();
		load_setup({m[1], m[0]}, {m[3], m[2]}, {m[5], m[4]}, {m[7], m[6]},
			{m[9], m[8]}, {m[11], m[10]}, wdata, hdata, 1'b0);
	endtask

	// Sender: random gap before each point, valid held until the transfer
	task automatic send_point(ppv_point_t p);
		int gap;
		if ($urandom_range(0, 31) == 0)
			src_burst = !src_burst;
		gap = src_burst ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			point_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		point <= p;
		point_valid <= 1'b1;
		@(posedge clk);
		while (!point_ready) @(posedge clk);
		sb.note_point(p);
	endtask

	// Stop sending and wait for every owed projection; block is idle afterwards
	task automatic drain();
		point_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Receiver: random stalls per result, with no-stall stretches
	initial begin
		int gap;
		proj_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				snk_burst = !snk_burst;
			gap = snk_burst ? 0 : $urandom_range(0, 12);
			if (gap > 0) begin
				proj_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			proj_ready <= 1'b1;
			@(posedge clk);
			while (!proj_valid) @(posedge clk);
			sb.check_proj(proj);
		end
	end

	// Stimulus
	initial begin
		arst_n <= 1'b0;
		point_valid <= 1'b0;
		point <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_ROW0_XY;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: zero matrix gives w = 0, so nothing is visible
		send_point(pt(32'h0, 32'h0, 32'h0));
		send_point(pt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_point(pt(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		drain();

		// Identity-like camera, w = z, standard 1920x1080 viewport
		load_setup({32'h0, FX_ONE}, 64'h0, {FX_ONE, 32'h0}, 64'h0,
			64'h0, {32'h0, FX_ONE}, 64'd1920, 64'd1080, 1'b0);
		send_point(pt(32'h0, 32'h0, 32'd42599));         // w exactly on the threshold
		send_point(pt(32'h0, 32'h0, 32'd42598));         // one LSB short of it
		send_point(pt(FX_ONE, FX_ONE, FX_ONE));          // x/w = 1 lands on the right edge
		send_point(pt(32'h7FFF_FFFF, 32'h8000_0000, FX_ONE)); // both coords clip high
		send_point(pt(32'h8000_0000, 32'h7FFF_FFFF, FX_ONE)); // both coords clip low
		send_point(pt(32'h0, 32'h0, 32'h7FFF_FFFF));     // largest w that fits depth
		send_point(pt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000)); // behind camera
		send_point(pt(32'hFFFF_FFFF, 32'h1, 32'h0002_0000));   // floor on a negative product
		drain();

		// w = z + max int: depth saturates; W beyond 8192, H = 0.
		// The unmapped write last must not disturb screen_width.
		load_setup({32'h8000_0000, 32'h7FFF_FFFF}, {32'h0, FX_ONE},
			{32'hFFFF_8000, 32'h0000_8000}, {32'hFF9C_0000, 32'h0},
			64'h0, {32'h7FFF_FFFF, FX_ONE}, 64'd16383, 64'd0, 1'b1);
		send_point(pt(32'h0, 32'h0, 32'h7FFF_FFFF));     // w near 2^32
		send_point(pt(32'h0, 32'h0, 32'h8000_A668));     // w = 42599
		send_point(pt(32'h0, 32'h0, 32'h8000_A667));     // w = 42598
		send_point(pt(32'h1, 32'hFFFF_FFFF, 32'h0));
		send_point(pt(32'h8000_0000, 32'h8000_0000, 32'h8000_0000)); // w = -1
		send_point(pt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0));
		drain();

		// Mixed-sign fractional matrix, W = 1, H = 8192
		load_setup({32'h0000_8000, 32'hFFFF_0000}, {32'h0064_0000, 32'hFFFF_C000},
			{32'h0002_0000, 32'h0000_4000}, {32'hFFFC_8000, 32'h0},
			64'h0, {FX_ONE, 32'h0000_8000}, 64'd1, 64'd8192, 1'b0);
		send_point(pt(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_point(pt(32'h0003_0000, 32'hFFF9_0000, 32'h000A_0000));
		send_point(pt(32'h1234_5678, 32'hEDCB_A987, 32'h00AB_CDEF));
		drain();

		// Random phases; each reload happens with the pipeline empty
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			random_setup();
			for (int n = 0; n < PHASE_POINTS; n++)
				send_point(rand_point());
			drain();
		end

		// Let any stray late transfer show up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
src/ppv_pkg.sv
src/perspective_projection_viewport_unit.sv
test/tb_top.sv
